// ===== rtl/bbcc_pkg.sv =====
package bbcc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam int NUM_W        = 44;
    localparam int AL_NW        = 40;
    localparam int AL_RW        = 17;
    localparam int CD_RW        = 40;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic neg;
        logic nneg;
        logic dz;
        logic nz;
        logic big;
    } coef_flags_t;

endpackage

// ===== rtl/bbcc_div_cell.sv =====
module bbcc_div_cell #(
    parameter int RW = 18,
    parameter int NW = 42,
    parameter int QW = 24,
    parameter int SW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] in_r,
    input  logic [NW-1:0] in_n,
    input  logic [RW-1:0] in_d,
    input  logic [QW-1:0] in_q,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [RW-1:0] out_r,
    output logic [NW-1:0] out_n,
    output logic [RW-1:0] out_d,
    output logic [QW-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [RW-1:0] r_reg, r_next, d_reg;
    logic [NW-1:0] n_reg, n_next;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;
    logic [RW:0]   t, diff;
    logic          ge;

    always_comb begin
        t      = {in_r, in_n[NW-1]};
        diff   = t - {1'b0, in_d};
        ge     = t >= {1'b0, in_d};
        r_next = ge ? diff[RW-1:0] : t[RW-1:0];
        q_next = {in_q[QW-2:0], ge};
        n_next = in_n << 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= r_next;
            n_reg    <= n_next;
            d_reg    <= in_d;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_n     = n_reg;
    assign out_d     = d_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/bbcc_div_chain.sv =====
module bbcc_div_chain #(
    parameter int N  = 42,
    parameter int RW = 18,
    parameter int NW = 42,
    parameter int QW = 24,
    parameter int SW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] in_r,
    input  logic [NW-1:0] in_n,
    input  logic [RW-1:0] in_d,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [RW-1:0] out_r,
    output logic [RW-1:0] out_d,
    output logic [QW-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          v_w    [N+1];
    logic [RW-1:0] r_w    [N+1];
    logic [NW-1:0] n_w    [N+1];
    logic [RW-1:0] d_w    [N+1];
    logic [QW-1:0] q_w    [N+1];
    logic [SW-1:0] side_w [N+1];

    assign v_w[0]    = in_valid;
    assign r_w[0]    = in_r;
    assign n_w[0]    = in_n;
    assign d_w[0]    = in_d;
    assign q_w[0]    = '0;
    assign side_w[0] = in_side;

    for (genvar i = 0; i < N; i++) begin : g_cell
        bbcc_div_cell #(.RW(RW), .NW(NW), .QW(QW), .SW(SW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_w[i]),
            .in_r      (r_w[i]),
            .in_n      (n_w[i]),
            .in_d      (d_w[i]),
            .in_q      (q_w[i]),
            .in_side   (side_w[i]),
            .out_valid (v_w[i+1]),
            .out_r     (r_w[i+1]),
            .out_n     (n_w[i+1]),
            .out_d     (d_w[i+1]),
            .out_q     (q_w[i+1]),
            .out_side  (side_w[i+1])
        );
    end

    assign out_valid = v_w[N];
    assign out_r     = r_w[N];
    assign out_d     = d_w[N];
    assign out_q     = q_w[N];
    assign out_side  = side_w[N];

endmodule

// ===== rtl/bbcc_cordic_cell.sv =====
module bbcc_cordic_cell #(
    parameter int STEP = 0,
    parameter int SW   = 17
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [bbcc_pkg::CW-1:0] in_x,
    input  logic signed [bbcc_pkg::CW-1:0] in_y,
    input  logic signed [bbcc_pkg::CW-1:0] in_z,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_valid,
    output logic signed [bbcc_pkg::CW-1:0] out_x,
    output logic signed [bbcc_pkg::CW-1:0] out_y,
    output logic signed [bbcc_pkg::CW-1:0] out_z,
    output logic [SW-1:0]                  out_side
);

    localparam logic signed [bbcc_pkg::CW-1:0] ATAN_STEP =
        $signed({{(bbcc_pkg::CW-32){1'b0}}, bbcc_pkg::ATAN_TURNS[STEP]});

    logic                           valid_reg;
    logic signed [bbcc_pkg::CW-1:0] x_reg, y_reg, z_reg, x_next, y_next, z_next, dx, dy;
    logic [SW-1:0]                  side_reg;

    always_comb begin
        dx = in_y >>> STEP;
        dy = in_x >>> STEP;
        if (!in_z[bbcc_pkg::CW-1]) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN_STEP;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/bandpass_biquad_coefficient_calc_top.sv =====
// Bandpass biquad coefficient calculator (constant skirt gain).
// Input stream: s_tvalid/s_tready/s_tdata carries a centre frequency in Hz and
// a Q factor in Q8.8. Result stream: m_tvalid/m_tready/m_tdata carries
// b0, b1, b2, a1, a2 normalised by a0 in signed Q2.F plus a saturation flag.
// cfg_we/cfg_wdata writes the sample rate; write only while the block is idle.
// The block is one pipeline of cells: a restoring divider row for the phase,
// a CORDIC rotation row, a divider row for alpha and three divider rows for
// the coefficients, one quotient bit or one rotation per cell.
// Throughput: one transaction per cycle sustained while m_tready stays high.
// Reset: aresetn low empties the pipeline and sets the sample rate to 48000.
// Stall: when a result waits with m_tready low, the whole pipeline holds and
// s_tready drops; it resumes as soon as the result is taken.
module bandpass_biquad_coefficient_calc_top #(
    parameter int COEF_FRAC_BITS = 22,
    parameter int PHASE_BITS     = 24,
    localparam int DATA_W        = ((5 * (COEF_FRAC_BITS + 2) + 1 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [17:0]         cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // center_freq[17:0], q_factor[33:18], zero padding
    input  logic [39:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, saturated, zero padding
    output logic [DATA_W-1:0]   m_tdata
);

    localparam int CFW    = COEF_FRAC_BITS + 2;
    localparam int PH_N   = 18 + PHASE_BITS;
    localparam int ANG_SH = 32 - PHASE_BITS;
    localparam int CW     = bbcc_pkg::CW;
    localparam int NUM_W  = bbcc_pkg::NUM_W;
    localparam int FLW    = $bits(bbcc_pkg::coef_flags_t);

    localparam logic signed [NUM_W-1:0] ONE_Q30 = 44'sd1073741824;
    localparam logic [CFW-1:0] COEF_HI = {1'b0, {(CFW-1){1'b1}}};
    localparam logic [CFW-1:0] COEF_LO = {1'b1, {(CFW-1){1'b0}}};
    localparam logic [CFW:0]   HI_U    = {2'b00, {(CFW-1){1'b1}}};
    localparam logic [CFW:0]   LO_U    = {2'b01, {(CFW-1){1'b0}}};

    logic [17:0] sample_rate_reg;
    logic        en;
    logic        m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= 18'd48000;
        end else if (cfg_we) begin
            sample_rate_reg <= cfg_wdata;
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // phase = ((fc mod rate) << PHASE_BITS) / rate
    logic [17:0]           rate_eff;
    logic [15:0]           qf_eff;
    logic                  ph_v;
    logic [PHASE_BITS-1:0] ph_q;
    logic [15:0]           ph_qf;

    assign rate_eff = (sample_rate_reg == 18'd0) ? 18'd1 : sample_rate_reg;
    assign qf_eff   = (s_tdata[33:18] == 16'd0) ? 16'd1 : s_tdata[33:18];

    bbcc_div_chain #(.N(PH_N), .RW(18), .NW(PH_N), .QW(PHASE_BITS), .SW(16)) u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_r      (18'd0),
        .in_n      ({s_tdata[17:0], {PHASE_BITS{1'b0}}}),
        .in_d      (rate_eff),
        .in_side   (qf_eff),
        .out_valid (ph_v),
        .out_r     (),
        .out_d     (),
        .out_q     (ph_q),
        .out_side  (ph_qf)
    );

    // fold into [-1/4, 1/4) turn
    logic [31:0] ang, ang_f;
    logic        flip;

    always_comb begin
        ang   = 32'(ph_q) << ANG_SH;
        flip  = ang[31] ^ ang[30];
        ang_f = flip ? (ang ^ 32'h8000_0000) : ang;
    end

    logic                 cv_w [bbcc_pkg::CORDIC_STEPS+1];
    logic signed [CW-1:0] cx_w [bbcc_pkg::CORDIC_STEPS+1];
    logic signed [CW-1:0] cy_w [bbcc_pkg::CORDIC_STEPS+1];
    logic signed [CW-1:0] cz_w [bbcc_pkg::CORDIC_STEPS+1];
    logic [16:0]          cs_w [bbcc_pkg::CORDIC_STEPS+1];

    assign cv_w[0] = ph_v;
    assign cx_w[0] = bbcc_pkg::CORDIC_GAIN;
    assign cy_w[0] = '0;
    assign cz_w[0] = $signed({{(CW-32){ang_f[31]}}, ang_f});
    assign cs_w[0] = {flip, ph_qf};

    for (genvar i = 0; i < bbcc_pkg::CORDIC_STEPS; i++) begin : g_cordic
        bbcc_cordic_cell #(.STEP(i), .SW(17)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv_w[i]),
            .in_x      (cx_w[i]),
            .in_y      (cy_w[i]),
            .in_z      (cz_w[i]),
            .in_side   (cs_w[i]),
            .out_valid (cv_w[i+1]),
            .out_x     (cx_w[i+1]),
            .out_y     (cy_w[i+1]),
            .out_z     (cz_w[i+1]),
            .out_side  (cs_w[i+1])
        );
    end

    // alpha magnitude = (|sin|*256 + q) / (2q)
    logic signed [CW-1:0] sinv, cosv, sabs;
    logic [15:0]          c_qf;
    logic [39:0]          al_num;

    always_comb begin
        c_qf   = cs_w[bbcc_pkg::CORDIC_STEPS][15:0];
        sinv   = cs_w[bbcc_pkg::CORDIC_STEPS][16] ? -cy_w[bbcc_pkg::CORDIC_STEPS]
                                                   : cy_w[bbcc_pkg::CORDIC_STEPS];
        cosv   = cs_w[bbcc_pkg::CORDIC_STEPS][16] ? -cx_w[bbcc_pkg::CORDIC_STEPS]
                                                   : cx_w[bbcc_pkg::CORDIC_STEPS];
        sabs   = sinv[CW-1] ? -sinv : sinv;
        al_num = {sabs[31:0], 8'd0} + 40'(c_qf);
    end

    logic              al_v;
    logic [39:0]       al_q;
    logic [2*CW-1:0]   al_side;

    bbcc_div_chain #(.N(bbcc_pkg::AL_NW), .RW(bbcc_pkg::AL_RW), .NW(bbcc_pkg::AL_NW),
                     .QW(bbcc_pkg::AL_NW), .SW(2*CW)) u_alpha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cv_w[bbcc_pkg::CORDIC_STEPS]),
        .in_r      (17'd0),
        .in_n      (al_num),
        .in_d      ({c_qf, 1'b0}),
        .in_side   ({sinv, cosv}),
        .out_valid (al_v),
        .out_r     (),
        .out_d     (),
        .out_q     (al_q),
        .out_side  (al_side)
    );

    // stage B: alpha and a0
    logic                    b_v_reg;
    logic signed [CW-1:0]    b_sin_reg, b_cos_reg;
    logic signed [NUM_W-1:0] b_alpha_reg, b_a0_reg, alpha_s, alpha_n;

    always_comb begin
        alpha_s = $signed({4'd0, al_q});
        alpha_n = al_side[2*CW-1] ? -alpha_s : alpha_s;
    end

    // stage C: signed numerators and denominators
    logic                    c_v_reg;
    logic signed [NUM_W-1:0] c_n_reg [3];
    logic signed [NUM_W-1:0] c_d_reg [3];
    logic signed [NUM_W-1:0] cos_ext;

    assign cos_ext = $signed({{(NUM_W-CW){b_cos_reg[CW-1]}}, b_cos_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= al_v;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sin_reg   <= al_side[2*CW-1:CW];
            b_cos_reg   <= al_side[CW-1:0];
            b_alpha_reg <= alpha_n;
            b_a0_reg    <= ONE_Q30 + alpha_n;
            c_n_reg[0]  <= $signed({{(NUM_W-CW){b_sin_reg[CW-1]}}, b_sin_reg});
            c_d_reg[0]  <= b_a0_reg <<< 1;
            c_n_reg[1]  <= -(cos_ext <<< 1);
            c_d_reg[1]  <= b_a0_reg;
            c_n_reg[2]  <= ONE_Q30 - b_alpha_reg;
            c_d_reg[2]  <= b_a0_reg;
        end
    end

    logic                 cd_v    [3];
    logic [CFW-1:0]       cd_q    [3];
    logic [bbcc_pkg::CD_RW-1:0] cd_r [3];
    logic [bbcc_pkg::CD_RW-1:0] cd_d [3];
    logic [FLW-1:0]       cd_fl   [3];

    for (genvar k = 0; k < 3; k++) begin : g_coef
        logic [NUM_W-1:0]     mn, md;
        bbcc_pkg::coef_flags_t fl;

        always_comb begin
            mn      = c_n_reg[k][NUM_W-1] ? NUM_W'(-c_n_reg[k]) : NUM_W'(c_n_reg[k]);
            md      = c_d_reg[k][NUM_W-1] ? NUM_W'(-c_d_reg[k]) : NUM_W'(c_d_reg[k]);
            fl.neg  = c_n_reg[k][NUM_W-1] ^ c_d_reg[k][NUM_W-1];
            fl.nneg = c_n_reg[k][NUM_W-1];
            fl.dz   = (md == '0);
            fl.nz   = (mn == '0);
            fl.big  = {2'b00, mn} >= {md, 2'b00};
        end

        bbcc_div_chain #(.N(CFW), .RW(bbcc_pkg::CD_RW), .NW(CFW), .QW(CFW), .SW(FLW)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (c_v_reg),
            .in_r      (mn[bbcc_pkg::CD_RW+1:2]),
            .in_n      ({mn[1:0], {COEF_FRAC_BITS{1'b0}}}),
            .in_d      (md[bbcc_pkg::CD_RW-1:0]),
            .in_side   (fl),
            .out_valid (cd_v[k]),
            .out_r     (cd_r[k]),
            .out_d     (cd_d[k]),
            .out_q     (cd_q[k]),
            .out_side  (cd_fl[k])
        );
    end

    function automatic logic [CFW:0] coef_final(
        input logic [CFW-1:0]             q,
        input logic [bbcc_pkg::CD_RW-1:0] r,
        input logic [bbcc_pkg::CD_RW-1:0] d,
        input bbcc_pkg::coef_flags_t      fl
    );
        logic           rnd;
        logic [CFW:0]   qr;
        logic [CFW-1:0] c;
        logic           f;
        rnd = {r, 1'b0} >= {1'b0, d};
        qr  = {1'b0, q} + (CFW+1)'(rnd);
        f   = 1'b0;
        priority if (fl.dz) begin
            if (fl.nz) begin
                c = '0;
            end else begin
                f = 1'b1;
                c = fl.nneg ? COEF_LO : COEF_HI;
            end
        end else if (fl.big) begin
            f = 1'b1;
            c = fl.neg ? COEF_LO : COEF_HI;
        end else if (!fl.neg) begin
            if (qr > HI_U) begin
                f = 1'b1;
                c = COEF_HI;
            end else begin
                c = qr[CFW-1:0];
            end
        end else begin
            if (qr > LO_U) begin
                f = 1'b1;
                c = COEF_LO;
            end else begin
                c = -qr[CFW-1:0];
            end
        end
        return {f, c};
    endfunction

    // stage D: rounding and clamping
    logic           d_v_reg, d_flag_reg;
    logic [CFW-1:0] d_b0_reg, d_a1_reg, d_a2_reg;
    logic [CFW:0]   fin0, fin1, fin2;

    always_comb begin
        fin0 = coef_final(cd_q[0], cd_r[0], cd_d[0], cd_fl[0]);
        fin1 = coef_final(cd_q[1], cd_r[1], cd_d[1], cd_fl[1]);
        fin2 = coef_final(cd_q[2], cd_r[2], cd_d[2], cd_fl[2]);
    end

    // output register
    logic signed [CFW-1:0] b0_reg, b2_reg, a1_reg, a2_reg;
    logic                  sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            d_v_reg      <= cd_v[0];
            m_tvalid_reg <= d_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_b0_reg   <= fin0[CFW-1:0];
            d_a1_reg   <= fin1[CFW-1:0];
            d_a2_reg   <= fin2[CFW-1:0];
            d_flag_reg <= fin0[CFW] | fin1[CFW] | fin2[CFW];
            b0_reg     <= d_b0_reg;
            b2_reg     <= (d_b0_reg == COEF_LO) ? COEF_HI : -d_b0_reg;
            a1_reg     <= d_a1_reg;
            a2_reg     <= d_a2_reg;
            sat_reg    <= d_flag_reg | (d_b0_reg == COEF_LO);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'({sat_reg, a2_reg, a1_reg, b2_reg, {CFW{1'b0}}, b0_reg});

    a_b2_neg_b0: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !sat_reg) |-> (b2_reg == -b0_reg))
        else $error("b2 is not the negation of b0 on an unsaturated result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("result valid directly after reset");

    a_rows_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (cd_v[0] == cd_v[1]) && (cd_v[1] == cd_v[2]))
        else $error("coefficient divider rows out of step");

endmodule
